@@ rtl/smhc_pkg.sv @@
// Package with the shared types, constants and saturation table generator of the heater control.
`timescale 1ns / 1ps

package smhc_pkg;

   typedef struct packed {
      logic [1:0]         chan;
      logic signed [15:0] measured_temp;
      logic signed [15:0] setpoint_temp;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_chan;
      logic [14:0] duty;
      logic        forced_off;
      logic        first_sample;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DIV_EDOT,
      ST_EDOT,
      ST_MUL,
      ST_SURF,
      ST_INDEX,
      ST_ROM,
      ST_GAIN,
      ST_SUM,
      ST_DIV_DUTY,
      ST_QUOT,
      ST_OUT
   } state_type;

   localparam logic [2:0] CSR_DUTY_LIMIT     = 3'd0;
   localparam logic [2:0] CSR_MODEL_SENS     = 3'd1;
   localparam logic [2:0] CSR_ROBUST_GAIN    = 3'd2;
   localparam logic [2:0] CSR_LAMBDA_HEATING = 3'd3;
   localparam logic [2:0] CSR_LAMBDA_COOLING = 3'd4;
   localparam logic [2:0] CSR_COOLING_MARGIN = 3'd5;

   localparam logic [9:0]  DT_DEFAULT_MS = 10'd100;
   localparam logic [31:0] DT_MAX_MS     = 32'd1000;
   localparam logic [35:0] EDOT_SCALE    = 36'd1024000;
   localparam logic [16:0] SAT_ONE       = 17'd65536;
   localparam int          SPAN_SHIFT    = 22;
   localparam int          DIV_WIDTH     = 36;

   localparam longint unsigned Q30_ONE  = 64'd1073741824;
   localparam longint unsigned Q30_EINV = 64'd395007542;

   // Unsigned quotient by shift and subtract, used only while building the table.
   function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = 64'd0;
      r = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         r = (r << 1) | ((num >> b) & 64'd1);
         if (r >= den) begin
            r = r - den;
            q = q | (64'd1 << b);
         end
      end
      return q;
   endfunction

   // e to the minus a, argument and result in unsigned Q30.
   function automatic longint unsigned exp_neg_q30(longint unsigned a);
      longint unsigned n;
      longint unsigned f;
      longint unsigned term;
      longint unsigned r;
      longint          acc;
      n    = a >> 30;
      f    = a & (Q30_ONE - 64'd1);
      term = Q30_ONE;
      acc  = longint'(Q30_ONE);
      for (int k = 1; k <= 16; k++) begin
         term = udiv64((term * f) >> 30, longint'(k));
         if ((k & 1) == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      r = (acc < 0) ? 64'd0 : longint'(acc);
      if (n > 64'd64) n = 64'd64;
      for (int j = 0; j < 64; j++) begin
         if (longint'(j) < longint'(n)) r = (r * Q30_EINV) >> 30;
      end
      return r;
   endfunction

   function automatic longint unsigned sigma_q30(longint unsigned a, bit neg);
      longint unsigned e;
      e = exp_neg_q30(a);
      if (neg) return udiv64(e << 30, Q30_ONE + e);
      return udiv64(Q30_ONE << 30, Q30_ONE + e);
   endfunction

   // Entry i of the normalized shifted tanh table for a table of the given depth.
   function automatic logic [16:0] sat_entry(int i, int depth);
      longint unsigned z0;
      longint unsigned den;
      longint          yn;
      longint unsigned mag;
      longint unsigned a;
      longint unsigned sg;
      longint unsigned num;
      z0  = sigma_q30(64'd3 * Q30_ONE, 1'b1);
      den = Q30_ONE - z0;
      yn  = 64 * longint'(i) - 15 * longint'(depth);
      mag = (yn < 0) ? longint'(-yn) : longint'(yn);
      a   = udiv64(mag << 30, 64'd5 * longint'(depth));
      sg  = sigma_q30(a, yn < 0);
      num = (sg > z0) ? sg - z0 : 64'd0;
      return 17'(udiv64(num * 64'd65536 + (den >> 1), den));
   endfunction

endpackage

@@ rtl/sliding_mode_heater_control.sv @@
// Top level of the sliding-mode heater duty controller with per-channel state memory.
//
// A request word carries a channel, a measured and a target temperature and a
// millisecond timestamp; exactly one response word with the channel and duty
// follows. Both channels move a word at a clock edge where valid is high and
// stall is low. Configuration registers are written through the csr port,
// which is always ready; the user must write them only while the block is
// idle, as the block does not enforce it. One request is worked on at a time.
// An ignored channel, a first sample or a forced-off sample goes from the
// check state straight to output without the divider; a full computation
// makes two 36-step passes through the shared bit-serial divider (derivative,
// then duty), and the second pass is skipped when the duty sum is not
// positive. A new request is accepted in the cycle after the response loads.
// Per-channel history lives in a small synchronous memory read at acceptance
// and written back when the response is loaded.
// Reset is synchronous: registers return to their defaults and all channel
// entries read as zero until written. When the receiver stalls, the response
// holds in its output register; the next request is still accepted and waits
// at its end for that register to free.
`timescale 1ns / 1ps

module sliding_mode_heater_control #(
   parameter int CHANNELS        = 4,
   parameter int SAT_TABLE_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smhc_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smhc_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TW = $clog2(SAT_TABLE_DEPTH);
   localparam int MW = 63;

   smhc_pkg::state_type state_ff, state_in;

   logic [14:0] duty_limit_ff;
   logic [15:0] model_sens_ff, robust_gain_ff, lambda_heat_ff, lambda_cool_ff;
   logic [14:0] cooling_margin_ff;

   smhc_pkg::req_type req_ff;
   logic              ignore_ff;

   logic [MW-1:0]     mem [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   logic [MW-1:0]     rd_ff;
   logic              rd_vld_ff;
   logic [AW-1:0]     addr;

   logic signed [15:0] err_ff, perr_ff;
   logic [14:0]        pduty_ff;
   logic [9:0]         dt_ff;
   logic               unset_ff;
   logic               neg_ff;
   logic signed [31:0] edot_ff, fhat_ff, s_ff;
   logic [30:0]        prod_m_ff;
   logic signed [48:0] prod_l_ff;
   logic [25:0]        idx_ff;
   logic [16:0]        satv_ff;
   logic [24:0]        w_ff;

   logic [35:0]        dvd_ff;
   logic [15:0]        dvs_ff, rem_ff;
   logic [5:0]         cnt_ff;

   logic [14:0]        res_duty_ff;
   logic               res_forced_ff, res_first_ff;
   logic               wr_en_ff;
   logic signed [15:0] wr_err_ff;
   logic [14:0]        wr_duty_ff;

   logic               rsp_valid_ff;
   smhc_pkg::rsp_type  rsp_ff;

   logic [16:0]        sat_tab [SAT_TABLE_DEPTH];

   logic               req_go, out_go, div_last;
   logic [16:0]        div_r2;
   logic               div_ge;
   logic               forced;
   logic signed [33:0] sum;

   logic [31:0]        rd_time;
   logic signed [15:0] rd_err;
   logic [14:0]        rd_duty;
   logic [31:0]        dt_raw;
   logic signed [16:0] err_raw;
   logic signed [16:0] diff;
   logic [15:0]        abs_diff;
   logic signed [36:0] q_signed;
   logic [15:0]        lam;
   logic signed [33:0] fh_wide;
   logic signed [40:0] s_lam;
   logic signed [41:0] s_wide;
   logic [31:0]        s_mag;
   logic [47:0]        idx_prod;

   for (genvar g = 0; g < SAT_TABLE_DEPTH; g++) begin : g_tab
      assign sat_tab[g] = smhc_pkg::sat_entry(g, SAT_TABLE_DEPTH);
   end

   assign req_stall = (state_ff != smhc_pkg::ST_IDLE);
   assign req_go    = req_valid && !req_stall;
   assign out_go    = (state_ff == smhc_pkg::ST_OUT) && (!rsp_valid_ff || !rsp_stall);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign addr      = AW'(req_stall ? req_ff.chan : req_word.chan);

   always_comb begin
      rd_time  = rd_vld_ff ? rd_ff[62:31] : 32'd0;
      rd_err   = rd_vld_ff ? $signed(rd_ff[30:15]) : 16'sd0;
      rd_duty  = rd_vld_ff ? rd_ff[14:0] : 15'd0;
      dt_raw   = req_ff.now_ms - rd_time;
      err_raw  = 17'(req_ff.setpoint_temp) - 17'(req_ff.measured_temp);
      diff     = 17'(err_ff) - 17'(perr_ff);
      abs_diff = diff[16] ? 16'(-diff) : 16'(diff);
      forced   = 17'(err_ff) < -$signed({2'b00, cooling_margin_ff});
      div_r2   = {rem_ff, dvd_ff[35]};
      div_ge   = div_r2 >= {1'b0, dvs_ff};
      div_last = (cnt_ff == 6'(smhc_pkg::DIV_WIDTH - 1));
      q_signed = neg_ff ? -$signed({1'b0, dvd_ff}) : $signed({1'b0, dvd_ff});
      lam      = (edot_ff > 0) ? lambda_cool_ff : lambda_heat_ff;
      fh_wide  = 34'(edot_ff) + $signed({3'b000, prod_m_ff});
      s_lam    = prod_l_ff[48] ? 41'((prod_l_ff + 49'sd255) >>> 8) : 41'(prod_l_ff >>> 8);
      s_wide   = 42'($signed({err_ff, 10'b0})) + 42'(s_lam);
      s_mag    = s_ff[31] ? 32'(-33'(s_ff)) : 32'(s_ff);
      idx_prod = 48'(s_mag) * 48'(SAT_TABLE_DEPTH);
      sum      = 34'(fhat_ff) + (s_ff[31] ? -$signed({9'b0, w_ff}) : $signed({9'b0, w_ff}));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         smhc_pkg::ST_IDLE:     if (req_go) state_in = smhc_pkg::ST_READ;
         smhc_pkg::ST_READ:     state_in = smhc_pkg::ST_CHECK;
         smhc_pkg::ST_CHECK:    state_in = (ignore_ff || unset_ff || forced) ?
                                           smhc_pkg::ST_OUT : smhc_pkg::ST_DIV_EDOT;
         smhc_pkg::ST_DIV_EDOT: if (div_last) state_in = smhc_pkg::ST_EDOT;
         smhc_pkg::ST_EDOT:     state_in = smhc_pkg::ST_MUL;
         smhc_pkg::ST_MUL:      state_in = smhc_pkg::ST_SURF;
         smhc_pkg::ST_SURF:     state_in = smhc_pkg::ST_INDEX;
         smhc_pkg::ST_INDEX:    state_in = smhc_pkg::ST_ROM;
         smhc_pkg::ST_ROM:      state_in = smhc_pkg::ST_GAIN;
         smhc_pkg::ST_GAIN:     state_in = smhc_pkg::ST_SUM;
         smhc_pkg::ST_SUM:      state_in = (sum > 0) ? smhc_pkg::ST_DIV_DUTY : smhc_pkg::ST_OUT;
         smhc_pkg::ST_DIV_DUTY: if (div_last) state_in = smhc_pkg::ST_QUOT;
         smhc_pkg::ST_QUOT:     state_in = smhc_pkg::ST_OUT;
         smhc_pkg::ST_OUT:      if (out_go) state_in = smhc_pkg::ST_IDLE;
         default:               state_in = smhc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= smhc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_limit_ff     <= 15'd25600;
         model_sens_ff     <= 16'd3072;
         robust_gain_ff    <= 16'd3840;
         lambda_heat_ff    <= 16'd256;
         lambda_cool_ff    <= 16'd0;
         cooling_margin_ff <= 15'd64;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            smhc_pkg::CSR_DUTY_LIMIT:     duty_limit_ff     <= csr_wdata[14:0];
            smhc_pkg::CSR_MODEL_SENS:     model_sens_ff     <= csr_wdata;
            smhc_pkg::CSR_ROBUST_GAIN:    robust_gain_ff    <= csr_wdata;
            smhc_pkg::CSR_LAMBDA_HEATING: lambda_heat_ff    <= csr_wdata;
            smhc_pkg::CSR_LAMBDA_COOLING: lambda_cool_ff    <= csr_wdata;
            smhc_pkg::CSR_COOLING_MARGIN: cooling_margin_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[addr];
      if (out_go && wr_en_ff) begin
         mem[addr] <= {req_ff.now_ms, wr_err_ff, wr_duty_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= vld_ff[addr];
         if (out_go && wr_en_ff) vld_ff[addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff) inside
         smhc_pkg::ST_IDLE: begin
            if (req_go) begin
               req_ff    <= req_word;
               ignore_ff <= (32'(req_word.chan) >= 32'(CHANNELS));
            end
         end
         smhc_pkg::ST_READ: begin
            unset_ff <= (rd_time == 32'd0);
            perr_ff  <= rd_err;
            pduty_ff <= rd_duty;
            dt_ff    <= (dt_raw == 32'd0 || dt_raw > smhc_pkg::DT_MAX_MS) ?
                        smhc_pkg::DT_DEFAULT_MS : dt_raw[9:0];
            if (err_raw > 17'sd32767) err_ff <= 16'sh7fff;
            else if (err_raw < -17'sd32768) err_ff <= 16'sh8000;
            else err_ff <= 16'(err_raw);
         end
         smhc_pkg::ST_CHECK: begin
            res_duty_ff   <= 15'd0;
            res_forced_ff <= !ignore_ff && !unset_ff && forced;
            res_first_ff  <= !ignore_ff && unset_ff;
            wr_en_ff      <= !ignore_ff;
            wr_err_ff     <= unset_ff ? perr_ff : err_ff;
            wr_duty_ff    <= unset_ff ? pduty_ff : 15'd0;
            neg_ff <= diff[16];
            dvd_ff <= 36'(abs_diff) * smhc_pkg::EDOT_SCALE;
            dvs_ff <= 16'(dt_ff);
            rem_ff <= 16'd0;
            cnt_ff <= 6'd0;
         end
         smhc_pkg::ST_DIV_EDOT, smhc_pkg::ST_DIV_DUTY: begin
            rem_ff <= div_ge ? 16'(div_r2 - {1'b0, dvs_ff}) : div_r2[15:0];
            dvd_ff <= {dvd_ff[34:0], div_ge};
            cnt_ff <= cnt_ff + 6'd1;
         end
         smhc_pkg::ST_EDOT: begin
            if (q_signed > 37'sd2147483647) edot_ff <= 32'sh7fffffff;
            else if (q_signed < -37'sd2147483648) edot_ff <= 32'sh80000000;
            else edot_ff <= 32'(q_signed);
         end
         smhc_pkg::ST_MUL: begin
            prod_m_ff <= 31'(model_sens_ff) * 31'(pduty_ff);
            prod_l_ff <= 49'($signed({1'b0, lam})) * 49'(edot_ff);
         end
         smhc_pkg::ST_SURF: begin
            if (fh_wide > 34'sd2147483647) fhat_ff <= 32'sh7fffffff;
            else if (fh_wide < -34'sd2147483648) fhat_ff <= 32'sh80000000;
            else fhat_ff <= 32'(fh_wide);
            if (s_wide > 42'sd2147483647) s_ff <= 32'sh7fffffff;
            else if (s_wide < -42'sd2147483648) s_ff <= 32'sh80000000;
            else s_ff <= 32'(s_wide);
         end
         smhc_pkg::ST_INDEX: begin
            idx_ff <= 26'(idx_prod >> smhc_pkg::SPAN_SHIFT);
         end
         smhc_pkg::ST_ROM: begin
            satv_ff <= (idx_ff < 26'(SAT_TABLE_DEPTH)) ? sat_tab[idx_ff[TW-1:0]] :
                       smhc_pkg::SAT_ONE;
         end
         smhc_pkg::ST_GAIN: begin
            w_ff <= 25'((33'(robust_gain_ff) * 33'(satv_ff)) >> 8);
         end
         smhc_pkg::ST_SUM: begin
            dvd_ff     <= 36'(sum);
            dvs_ff     <= (model_sens_ff == 16'd0) ? 16'd1 : model_sens_ff;
            rem_ff     <= 16'd0;
            cnt_ff     <= 6'd0;
            res_duty_ff <= 15'd0;
            wr_duty_ff  <= 15'd0;
         end
         smhc_pkg::ST_QUOT: begin
            if (dvd_ff > 36'(duty_limit_ff)) begin
               res_duty_ff <= duty_limit_ff;
               wr_duty_ff  <= duty_limit_ff;
            end else begin
               res_duty_ff <= dvd_ff[14:0];
               wr_duty_ff  <= dvd_ff[14:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_go) begin
         rsp_ff.out_chan     <= req_ff.chan;
         rsp_ff.duty         <= res_duty_ff;
         rsp_ff.forced_off   <= res_forced_ff;
         rsp_ff.first_sample <= res_first_ff;
      end
   end

`ifndef SYNTHESIS
   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.duty <= duty_limit_ff)
      else $error("duty above limit");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.forced_off && rsp_word.first_sample))
      else $error("forced_off and first_sample both set");

   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.forced_off || rsp_word.first_sample) |-> rsp_word.duty == 15'd0)
      else $error("flagged word with nonzero duty");

   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == smhc_pkg::ST_DIV_EDOT || state_ff == smhc_pkg::ST_DIV_DUTY)
      |-> cnt_ff < 6'(smhc_pkg::DIV_WIDTH))
      else $error("divider overran");

   a_out_once: assert property (@(posedge clock) disable iff (reset)
      out_go |=> state_ff == smhc_pkg::ST_IDLE)
      else $error("response loaded without return to idle");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sliding-mode heater duty controller.
`timescale 1ns / 1ps

module tb_top;

   localparam int NCH       = 4;
   localparam int ROM_DEPTH = 256;
   localparam int STALL_LIMIT = 20000;
   localparam longint unsigned ONE30  = 64'd1073741824;
   localparam longint unsigned EINV30 = 64'd395007542;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   smhc_pkg::req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   smhc_pkg::rsp_type rsp_word;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   sliding_mode_heater_control dut (.*);

   always #10 clock = ~clock;

   logic [16:0] tanh_rom [ROM_DEPTH];
   longint duty_max, alpha_reg, gain_reg, lam_heat, lam_cool, margin_reg;
   logic [31:0] last_stamp [NCH];
   longint last_err [NCH];
   longint last_duty [NCH];

   smhc_pkg::req_type pending_words [$];
   smhc_pkg::rsp_type awaited_duties [$];
   bit req_taken = 1'b0;
   bit hold_sender = 1'b1;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int errors = 0;
   int words_in = 0;
   int words_out = 0;
   int forced_count = 0;
   int first_count = 0;
   int quiet_cycles = 0;
   logic [31:0] stamp [NCH];

   function automatic longint unsigned decay_q30(longint unsigned a);
      longint unsigned whole, frac, term, r;
      longint acc;
      whole = a >> 30;
      frac  = a & (ONE30 - 1);
      term  = ONE30;
      acc   = longint'(ONE30);
      for (int k = 1; k <= 16; k++) begin
         term = ((term * frac) >> 30) / longint'(k);
         acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
      end
      r = (acc < 0) ? 0 : longint'(acc);
      if (whole > 64) whole = 64;
      while (whole > 0) begin
         r = (r * EINV30) >> 30;
         whole--;
      end
      return r;
   endfunction

   function automatic longint unsigned logistic_q30(longint unsigned a, bit neg);
      longint unsigned e;
      e = decay_q30(a);
      return neg ? (e << 30) / (ONE30 + e) : (ONE30 << 30) / (ONE30 + e);
   endfunction

   function automatic void build_tanh_rom();
      longint unsigned base, span, mag, sg, num;
      longint shifted;
      base = logistic_q30(3 * ONE30, 1'b1);
      span = ONE30 - base;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         shifted = 64 * longint'(i) - 15 * longint'(ROM_DEPTH);
         mag = (shifted < 0) ? longint'(-shifted) : longint'(shifted);
         sg  = logistic_q30((mag << 30) / (5 * longint'(ROM_DEPTH)), shifted < 0);
         num = (sg > base) ? sg - base : 0;
         tanh_rom[i] = 17'((num * 65536 + span / 2) / span);
      end
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic smhc_pkg::rsp_type predict_duty(smhc_pkg::req_type w);
      smhc_pkg::rsp_type r;
      int ch;
      logic [31:0] dt;
      longint err, edot, lam, fhat, surf, wsw, alpha, duty;
      longint unsigned mag, idx, satv;
      r = '0;
      ch = w.chan;
      r.out_chan = w.chan;
      if (last_stamp[ch] == 32'd0) begin
         last_stamp[ch] = w.now_ms;
         r.first_sample = 1'b1;
         return r;
      end
      dt = w.now_ms - last_stamp[ch];
      last_stamp[ch] = w.now_ms;
      if (dt == 32'd0 || dt > 32'd1000) dt = 32'd100;
      err = clip(longint'($signed(w.setpoint_temp)) - longint'($signed(w.measured_temp)),
                 -32768, 32767);
      if (err < -margin_reg) begin
         last_err[ch] = err;
         last_duty[ch] = 0;
         r.forced_off = 1'b1;
         return r;
      end
      edot = clip((err - last_err[ch]) * 1024000 / longint'(dt), -(64'sd1 <<< 31),
                  (64'sd1 <<< 31) - 1);
      lam  = (edot > 0) ? lam_cool : lam_heat;
      fhat = clip(edot + alpha_reg * last_duty[ch], -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      surf = clip(err * 1024 + (lam * edot) / 256, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
      mag  = (surf < 0) ? longint'(-surf) : longint'(surf);
      idx  = mag * ROM_DEPTH / (64'd64 << 16);
      satv = (idx < ROM_DEPTH) ? longint'(tanh_rom[idx]) : 65536;
      wsw  = longint'((longint'(gain_reg) * satv) >> 8);
      if (surf < 0) wsw = -wsw;
      alpha = (alpha_reg == 0) ? 1 : alpha_reg;
      duty = clip((fhat + wsw) / alpha, 0, duty_max);
      last_err[ch] = err;
      last_duty[ch] = duty;
      r.duty = 15'(duty);
      return r;
   endfunction

   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (!hold_sender && pending_words.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            req_word  <= pending_words.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      smhc_pkg::rsp_type got, want;
      bit moved;
      moved = 1'b0;
      req_taken <= (!reset && req_valid && !req_stall);
      if (!reset && req_valid && !req_stall) begin
         awaited_duties.push_back(predict_duty(req_word));
         words_in++;
         moved = 1'b1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_word;
         moved = 1'b1;
         words_out++;
         if (awaited_duties.size() == 0) begin
            $error("unexpected duty word %p", got);
            errors++;
         end else begin
            want = awaited_duties.pop_front();
            forced_count += want.forced_off;
            first_count += want.first_sample;
            if (got.out_chan !== want.out_chan) begin
               $error("out_chan expected %0d actual %0d", want.out_chan, got.out_chan);
               errors++;
            end
            if (got.duty !== want.duty) begin
               $error("duty expected %0d actual %0d", want.duty, got.duty);
               errors++;
            end
            if (got.forced_off !== want.forced_off) begin
               $error("forced_off expected %0b actual %0b", want.forced_off, got.forced_off);
               errors++;
            end
            if (got.first_sample !== want.first_sample) begin
               $error("first_sample expected %0b actual %0b", want.first_sample,
                      got.first_sample);
               errors++;
            end
         end
      end
      if (moved || (pending_words.size() == 0 && awaited_duties.size() == 0 && !req_valid))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("sliding_mode_heater_control regression: fail");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         smhc_pkg::CSR_DUTY_LIMIT:     duty_max   = value & 16'h7FFF;
         smhc_pkg::CSR_MODEL_SENS:     alpha_reg  = value;
         smhc_pkg::CSR_ROBUST_GAIN:    gain_reg   = value;
         smhc_pkg::CSR_LAMBDA_HEATING: lam_heat   = value;
         smhc_pkg::CSR_LAMBDA_COOLING: lam_cool   = value;
         smhc_pkg::CSR_COOLING_MARGIN: margin_reg = value & 16'h7FFF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_all(int dl, int ms, int rg, int lh, int lc, int cm);
      write_reg(smhc_pkg::CSR_DUTY_LIMIT, 16'(dl));
      write_reg(smhc_pkg::CSR_MODEL_SENS, 16'(ms));
      write_reg(smhc_pkg::CSR_ROBUST_GAIN, 16'(rg));
      write_reg(smhc_pkg::CSR_LAMBDA_HEATING, 16'(lh));
      write_reg(smhc_pkg::CSR_LAMBDA_COOLING, 16'(lc));
      write_reg(smhc_pkg::CSR_COOLING_MARGIN, 16'(cm));
   endtask

   task automatic drain();
      hold_sender = 1'b0;
      @(negedge clock);
      while (pending_words.size() > 0 || req_valid || awaited_duties.size() > 0)
         @(negedge clock);
      hold_sender = 1'b1;
      repeat (100) @(negedge clock);
   endtask

   task automatic queue_word(int ch, int meas, int targ, logic [31:0] ms);
      smhc_pkg::req_type w;
      w.chan = 2'(ch);
      w.measured_temp = 16'(meas);
      w.setpoint_temp = 16'(targ);
      w.now_ms = ms;
      pending_words.push_back(w);
   endtask

   task automatic queue_random(int count);
      int ch, targ, pick;
      logic [31:0] step;
      for (int n = 0; n < count; n++) begin
         ch = $urandom_range(NCH - 1);
         pick = $urandom_range(99);
         if (pick < 10) begin
            queue_word(ch, $urandom, $urandom, $urandom);
         end else begin
            if (pick < 14) step = 0;
            else if (pick < 18) step = $urandom_range(5000, 1001);
            else step = $urandom_range(1000, 1);
            stamp[ch] = stamp[ch] + step;
            targ = $urandom_range(9000, 0) - 1000;
            if (pick < 28)
               queue_word(ch, targ + $urandom_range(20000, 50), targ, stamp[ch]);
            else
               queue_word(ch, targ + int'($urandom_range(1200)) - 600, targ, stamp[ch]);
         end
      end
   endtask

   initial begin
      build_tanh_rom();
      duty_max = 25600; alpha_reg = 3072; gain_reg = 3840;
      lam_heat = 256; lam_cool = 0; margin_reg = 64;
      for (int c = 0; c < NCH; c++) begin
         last_stamp[c] = 0; last_err[c] = 0; last_duty[c] = 0; stamp[c] = 1000 + c;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_idle_pct = 30; recv_stall_pct = 76;

      queue_word(0, 0, 0, 32'd0);
      queue_word(0, 1600, 1600, 32'd50);
      queue_word(0, -32768, 32767, 32'd150);
      queue_word(0, 32767, -32768, 32'd150);
      queue_word(0, 1000, 2000, 32'd5000);
      queue_word(0, 2000, 1000, 32'd5010);
      queue_word(0, 1665, 1600, 32'd5020);
      queue_word(0, 1664, 1600, 32'd5030);
      queue_word(1, 0, 0, 32'hFFFF_FFFF);
      queue_word(1, 100, 300, 32'd999);
      queue_word(1, 500, 300, 32'd1999);
      queue_word(1, 300, 5000, 32'd0);
      queue_word(1, 300, 5000, 32'd7);
      queue_word(2, -32768, -32768, 32'h8000_0000);
      queue_word(2, -20000, 32767, 32'h8000_0001);
      queue_word(2, 32767, 32767, 32'h8000_0002);
      queue_word(3, 0, 64, 32'h5555_5555);
      queue_word(3, 0, 6400, 32'hAAAA_AAAA);
      queue_word(3, 6400, 0, 32'hAAAA_AAAB);
      queue_random(250);
      drain();

      set_all(25600, 1, 65535, 65535, 65535, 0);
      queue_random(250);
      drain();

      send_idle_pct = 76; recv_stall_pct = 30;
      set_all(0, 65535, 0, 0, 0, 32767);
      queue_random(200);
      drain();
      set_all(12000, 2048, 5000, 512, 384, 128);
      queue_random(300);
      drain();

      send_idle_pct = 0; recv_stall_pct = 0;
      set_all(25600, 3072, 3840, 256, 100, 64);
      queue_random(300);
      drain();

      $display("Covered %0d request words and %0d duty words over five register settings.",
               words_in, words_out);
      $display("Forced-off answers: %0d, first-sample answers: %0d.", forced_count,
               first_count);
      if (errors == 0)
         $display("sliding_mode_heater_control regression: pass");
      else
         $display("sliding_mode_heater_control regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/smhc_pkg.sv
rtl/sliding_mode_heater_control.sv
tb/tb_top.sv
